[rtl/dfd_pkg.sv]
// shared constants for the discrete frechet distance unit
package dfd_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 24;

  localparam int DSQ_W    = 50;
  localparam int DIST_W   = 25;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

[rtl/discrete_frechet_distance_unit.sv]
// discrete frechet distance over two loaded paths, one shared multiplier
//
//  channel   ports                                           beat marked by
//  point     path_select point_x point_y final_point         start && !busy
//  result    distance_squared distance status                done
//
// a point that is not final is taken and the block stays ready
// a final point runs n*m cells, each through read, diff, two squares
// through the one multiplier and combine, then the square root;
// busy stays high for all of it
// an empty path answers from the check state that follows the final point
// rst is synchronous and clears counts; point and row memories need no clear
// done lasts one cycle and the receiver cannot stall it
module discrete_frechet_distance_unit #(
  parameter int MAX_POINTS = dfd_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = dfd_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          path_select,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic                          final_point,
  output logic                          done,
  output logic [dfd_pkg::DSQ_W-1:0]     distance_squared,
  output logic [dfd_pkg::DIST_W-1:0]    distance,
  output logic [dfd_pkg::STATUS_W-1:0]  status
);

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DFW = COORD_BITS + 1;
  localparam int DW = 2 * COORD_BITS + 2;
  localparam int RW = (DW + 1) / 2;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_RD, S_DIFF, S_SQX, S_SQY, S_CELL, S_ROOT
  } state_t;

  state_t state;

  logic [2*COORD_BITS-1:0] mem_a [MAX_POINTS];
  logic [2*COORD_BITS-1:0] mem_b [MAX_POINTS];
  logic [DW-1:0]           dp_mem [MAX_POINTS];

  logic [CW-1:0] cnt_a, cnt_b;
  logic          ovf;
  logic [AW-1:0] ri, rj;
  logic [2*COORD_BITS-1:0] pa, pb;
  logic [DW-1:0] up_q, left, diag, acc, sq;
  logic [DFW-1:0] dx, dy;
  logic          accept;
  logic [2*COORD_BITS-1:0] pt;

  logic signed [DFW-1:0] ddx, ddy;
  logic [DFW-1:0] mop;
  logic [DW-1:0]  prod, dcell, best, cval;
  logic           first_row, first_col, last_i, last_j;
  logic           rt_start, rt_done;
  logic [RW-1:0]  rt_root;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign pt     = {point_x, point_y};

  // point memories, written on load and read one entry per cell
  always_ff @(posedge clk) begin
    if (accept && !path_select && (cnt_a < CW'(MAX_POINTS)))
      mem_a[cnt_a[AW-1:0]] <= pt;
    if (accept && path_select && (cnt_b < CW'(MAX_POINTS)))
      mem_b[cnt_b[AW-1:0]] <= pt;
    if (state == S_RD) begin
      pa <= mem_a[ri];
      pb <= mem_b[rj];
    end
  end

  // one row of the dynamic program
  always_ff @(posedge clk) begin
    if (state == S_CELL)
      dp_mem[rj] <= cval;
    if (state == S_RD)
      up_q <= dp_mem[rj];
  end

  assign ddx = DFW'($signed(pa[2*COORD_BITS-1:COORD_BITS]))
             - DFW'($signed(pb[2*COORD_BITS-1:COORD_BITS]));
  assign ddy = DFW'($signed(pa[COORD_BITS-1:0])) - DFW'($signed(pb[COORD_BITS-1:0]));

  // the shared multiplier squares dx then dy
  assign mop  = (state == S_SQX) ? dx : dy;
  assign prod = DW'(mop) * DW'(mop);

  assign first_row = (ri == '0);
  assign first_col = (rj == '0);
  assign last_i    = (CW'(ri) == cnt_a - CW'(1));
  assign last_j    = (CW'(rj) == cnt_b - CW'(1));
  assign dcell     = acc + sq;

  always_comb begin
    best = up_q;
    if (diag < best) best = diag;
    if (left < best) best = left;
    if (first_row && first_col)
      cval = dcell;
    else if (first_row)
      cval = (left > dcell) ? left : dcell;
    else if (first_col)
      cval = (up_q > dcell) ? up_q : dcell;
    else
      cval = (best > dcell) ? best : dcell;
  end

  assign rt_start = (state == S_CELL) && last_i && last_j;

  dfd_isqrt #(.DW(DW)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (rt_start),
    .value (cval),
    .done  (rt_done),
    .root  (rt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt_a <= '0;
      cnt_b <= '0;
      ovf   <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!path_select) begin
              if (cnt_a < CW'(MAX_POINTS)) cnt_a <= cnt_a + CW'(1);
              else ovf <= 1'b1;
            end else begin
              if (cnt_b < CW'(MAX_POINTS)) cnt_b <= cnt_b + CW'(1);
              else ovf <= 1'b1;
            end
            if (final_point) state <= S_CHK;
          end
        end
        S_CHK: begin
          ri <= '0;
          rj <= '0;
          if (cnt_a == '0 || cnt_b == '0) begin
            distance_squared <= '0;
            distance         <= '0;
            status           <= dfd_pkg::ST_EMPTY;
            done             <= 1'b1;
            cnt_a            <= '0;
            cnt_b            <= '0;
            ovf              <= 1'b0;
            state            <= S_IDLE;
          end else begin
            state <= S_RD;
          end
        end
        S_RD: state <= S_DIFF;
        S_DIFF: begin
          dx    <= ddx[DFW-1] ? DFW'(-ddx) : DFW'(ddx);
          dy    <= ddy[DFW-1] ? DFW'(-ddy) : DFW'(ddy);
          state <= S_SQX;
        end
        S_SQX: begin
          acc   <= prod;
          state <= S_SQY;
        end
        S_SQY: begin
          sq    <= prod;
          state <= S_CELL;
        end
        S_CELL: begin
          left <= cval;
          if (!first_row) diag <= up_q;
          if (last_j) begin
            rj <= '0;
            ri <= ri + AW'(1);
            // diag for the next row's first cell is unused
          end else begin
            rj <= rj + AW'(1);
          end
          if (last_i && last_j) begin
            distance_squared <= dfd_pkg::DSQ_W'(cval);
            state            <= S_ROOT;
          end else begin
            state <= S_RD;
          end
        end
        S_ROOT: begin
          if (rt_done) begin
            distance <= dfd_pkg::DIST_W'(rt_root);
            status   <= ovf ? dfd_pkg::ST_OVERFLOW : dfd_pkg::ST_OK;
            done     <= 1'b1;
            cnt_a    <= '0;
            cnt_b    <= '0;
            ovf      <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/dfd_isqrt.sv]
// bit-pair floor square root, one result bit per cycle
module dfd_isqrt #(
  parameter int DW = 50
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DW-1:0]         value,
  output logic                  done,
  output logic [(DW+1)/2-1:0]   root
);

  localparam int K  = (DW + 1) / 2;
  localparam int SW = 2 * K;
  localparam int CW = $clog2(K + 1);

  logic [SW-1:0] rem;
  logic [SW-1:0] res;
  logic [SW-1:0] bitm;
  logic [CW-1:0] cnt;
  logic          run;
  logic [SW-1:0] trial;

  assign trial = res + bitm;
  assign root  = res[K-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= SW'(value);
        res  <= '0;
        bitm <= SW'(1) << (SW - 2);
        cnt  <= CW'(K);
        run  <= 1'b1;
      end else if (run) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/dfd_checker.sv]
// port-level checks for the discrete frechet distance unit
module dfd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          final_point,
  input logic                          done,
  input logic [dfd_pkg::DSQ_W-1:0]     distance_squared,
  input logic [dfd_pkg::DIST_W-1:0]    distance,
  input logic [dfd_pkg::STATUS_W-1:0]  status
);

  // a plain point never takes the block away
  a_plain_stays_ready: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !final_point |=> !busy)
    else $error("busy after plain point");

  // a final point always starts a run
  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && final_point |=> busy)
    else $error("final point did not start a run");

  // a result beat only comes out of a run
  a_done_from_run: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result beat outside a run");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == dfd_pkg::ST_EMPTY |-> distance_squared == '0 && distance == '0)
    else $error("empty path gave nonzero distance");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == dfd_pkg::ST_OK || status == dfd_pkg::ST_EMPTY
             || status == dfd_pkg::ST_OVERFLOW)
    else $error("bad status code");

endmodule

bind discrete_frechet_distance_unit dfd_checker u_dfd_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .final_point      (final_point),
  .done             (done),
  .distance_squared (distance_squared),
  .distance         (distance),
  .status           (status)
);

[tb/tb_discrete_frechet_distance_unit.sv]
// testbench for discrete_frechet_distance_unit: random point loads against a local predictor
module tb_discrete_frechet_distance_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = dfd_pkg::MAX_POINTS_DEF;
  localparam int CW   = dfd_pkg::COORD_BITS_DEF;

  typedef struct {
    logic          sel;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          fin;
    int            gap_pct;
  } point_beat_t;

  typedef struct {
    logic [dfd_pkg::DSQ_W-1:0]    dsq;
    logic [dfd_pkg::DIST_W-1:0]   root;
    logic [dfd_pkg::STATUS_W-1:0] st;
  } answer_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic path_select = 0;
  logic signed [CW-1:0] point_x = '0;
  logic signed [CW-1:0] point_y = '0;
  logic final_point = 0;
  logic busy, done;
  logic [dfd_pkg::DSQ_W-1:0] distance_squared;
  logic [dfd_pkg::DIST_W-1:0] distance;
  logic [dfd_pkg::STATUS_W-1:0] status;

  discrete_frechet_distance_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .path_select(path_select), .point_x(point_x), .point_y(point_y),
    .final_point(final_point), .done(done),
    .distance_squared(distance_squared), .distance(distance), .status(status)
  );

  always #6 clk = ~clk;

  point_beat_t pending_points[$];
  answer_t     expected_answers[$];
  int issued = 0;
  int accepted = 0;
  bit failed = 0;
  int cur_gap = 0;

  // predictor state
  longint p0x[NPTS], p0y[NPTS], p1x[NPTS], p1y[NPTS];
  longint unsigned row[NPTS];
  int cnt0 = 0, cnt1 = 0;
  bit lost_point = 0;

  function automatic longint unsigned pair_dsq(int i, int j);
    longint dx, dy;
    dx = p0x[i] - p1x[j];
    dy = p0y[i] - p1y[j];
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned frechet_sq();
    longint unsigned diag, up, best, d;
    row[0] = pair_dsq(0, 0);
    for (int j = 1; j < cnt1; j++) begin
      d = pair_dsq(0, j);
      row[j] = (row[j-1] > d) ? row[j-1] : d;
    end
    for (int i = 1; i < cnt0; i++) begin
      diag = row[0];
      d = pair_dsq(i, 0);
      if (d > row[0]) row[0] = d;
      for (int j = 1; j < cnt1; j++) begin
        up = row[j];
        best = (up < diag) ? up : diag;
        if (row[j-1] < best) best = row[j-1];
        diag = up;
        d = pair_dsq(i, j);
        row[j] = (best > d) ? best : d;
      end
    end
    return row[cnt1-1];
  endfunction

  task automatic take_point(logic sel, logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic fin);
    answer_t a;
    longint unsigned dsq;
    longint unsigned root_full;
    if (!sel) begin
      if (cnt0 < NPTS) begin
        p0x[cnt0] = x; p0y[cnt0] = y; cnt0++;
      end else lost_point = 1;
    end else begin
      if (cnt1 < NPTS) begin
        p1x[cnt1] = x; p1y[cnt1] = y; cnt1++;
      end else lost_point = 1;
    end
    if (fin) begin
      if (cnt0 == 0 || cnt1 == 0) begin
        dsq = 0;
        a.st = dfd_pkg::ST_EMPTY;
      end else begin
        dsq = frechet_sq();
        a.st = lost_point ? dfd_pkg::ST_OVERFLOW : dfd_pkg::ST_OK;
      end
      a.dsq = dsq[dfd_pkg::DSQ_W-1:0];
      root_full = floor_sqrt(dsq);
      a.root = root_full[dfd_pkg::DIST_W-1:0];
      expected_answers = {expected_answers, a};
      cnt0 = 0; cnt1 = 0; lost_point = 0;
    end
  endtask

  // monitor and predictor share the rising edge
  always @(posedge clk) begin
    answer_t e;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result dsq=%0d dist=%0d status=%0d",
                 $time, distance_squared, distance, status);
        failed = 1;
      end else begin
        e = expected_answers[0];
        expected_answers.delete(0);
        if (distance_squared !== e.dsq) begin
          $display("%0t: distance_squared expected %0d actual %0d", $time, e.dsq,
                   distance_squared);
          failed = 1;
        end
        if (distance !== e.root) begin
          $display("%0t: distance expected %0d actual %0d", $time, e.root, distance);
          failed = 1;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          failed = 1;
        end
      end
    end
    if (!rst && start && !busy) begin
      take_point(path_select, point_x, point_y, final_point);
      accepted++;
    end
  end

  // driver: a new beat goes out once the previous one was taken
  always @(negedge clk) begin
    point_beat_t p;
    if (!rst && issued == accepted) begin
      if (pending_points.size() != 0 &&
          !(cur_gap > 0 && $urandom_range(99) < cur_gap)) begin
        p = pending_points[0];
        pending_points.delete(0);
        cur_gap = p.gap_pct;
        path_select <= p.sel;
        point_x <= p.x;
        point_y <= p.y;
        final_point <= p.fin;
        start <= 1;
        issued++;
      end else begin
        if (pending_points.size() != 0) cur_gap = pending_points[0].gap_pct;
        start <= 0;
      end
    end
  end

  function automatic logic [CW-1:0] rand_coord(bit wide);
    if (wide) return CW'($urandom());
    return CW'($urandom_range(4000)) - CW'(2000);
  endfunction

  task automatic add_point(logic sel, logic [CW-1:0] x, logic [CW-1:0] y, logic fin,
                           int pct);
    point_beat_t p;
    p.sel = sel; p.x = x; p.y = y; p.fin = fin; p.gap_pct = pct;
    pending_points = {pending_points, p};
  endtask

  // one load of n first-path and m second-path points in random order, last one final
  task automatic push_load(int n, int m, bit wide, int pct);
    int left0, left1;
    logic sel;
    left0 = n;
    left1 = m;
    while (left0 + left1 > 0) begin
      if (left0 == 0) sel = 1;
      else if (left1 == 0) sel = 0;
      else sel = 1'($urandom_range(1));
      if (sel) left1--; else left0--;
      add_point(sel, rand_coord(wide), rand_coord(wide), left0 + left1 == 0, pct);
    end
  endtask

  initial begin
    int pct;
    int loads;
    logic [CW-1:0] maxc, minc;
    maxc = {1'b0, {(CW-1){1'b1}}};
    minc = {1'b1, {(CW-1){1'b0}}};
    // extremes, single points each
    add_point(0, maxc, maxc, 0, 0);
    add_point(1, minc, minc, 1, 0);
    add_point(1, minc, maxc, 0, 0);
    add_point(0, maxc, minc, 1, 0);
    add_point(0, '0, '0, 0, 0);
    add_point(1, '0, '0, 1, 0);
    // empty second path, then empty first path
    add_point(0, maxc, '0, 0, 0);
    add_point(0, minc, '0, 1, 0);
    add_point(1, '1, '1, 1, 0);
    push_load(3, 4, 1, 0);
    // path full on each side
    push_load(66, 1, 0, 0);
    push_load(1, 65, 0, 0);

    loads = 0;
    while (pending_points.size() < 1000) begin
      case ((loads / 15) % 4)
        0: pct = 0;
        1: pct = 58;
        2: pct = 0;
        default: pct = 29;
      endcase
      if (loads % 40 == 39)
        push_load(64 + $urandom_range(3), 64 + $urandom_range(3), 1'($urandom_range(1)),
                  pct);
      else if ($urandom_range(19) == 0)
        push_load($urandom_range(1) ? 0 : 2, $urandom_range(1), 1'($urandom_range(1)),
                  pct);
      else
        push_load(1 + $urandom_range(6), 1 + $urandom_range(6), 1'($urandom_range(1)),
                  pct);
      loads++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    wait (pending_points.size() == 0 && issued == accepted);
    @(negedge clk);
    wait (expected_answers.size() == 0);
    repeat (50) @(posedge clk);
    if (!failed)
      $display("tb_discrete_frechet_distance_unit: PASS");
    else
      $display("tb_discrete_frechet_distance_unit: FAIL");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("tb_discrete_frechet_distance_unit: FAIL");
    $finish;
  end

endmodule
